// ----- rtl/pfp_pkg.sv -----
// ----------------------------------------------------------------------------
// Pixel format packer package
// Shared types and codes: channel payloads, queue entry, formats, registers.
// ----------------------------------------------------------------------------
package pfp_pkg;

    // Output pixel formats (out_format register)
    localparam logic [2:0] FMT_RGB555 = 3'd0;
    localparam logic [2:0] FMT_RGB565 = 3'd1;
    localparam logic [2:0] FMT_RGB24  = 3'd2;
    localparam logic [2:0] FMT_BGR24  = 3'd3;
    localparam logic [2:0] FMT_ARGB32 = 3'd4;

    // Item actions
    localparam logic ACT_PIXEL   = 1'b0;
    localparam logic ACT_PAL_WR  = 1'b1;

    // Configuration register indexes
    localparam logic CFG_OUT_FORMAT  = 1'b0;
    localparam logic CFG_SRC_INDEXED = 1'b1;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;   // pointer width
    localparam int QCW    = 3;   // level width, holds QDEPTH itself

    typedef struct packed {
        logic        action;
        logic [31:0] color;
        logic [7:0]  index;
        logic        row_end;
    } in_item_t;

    typedef struct packed {
        logic [31:0] out_word;
        logic [2:0]  bytes_valid;
        logic        last_of_row;
    } out_item_t;

    // Converted pixel: bytes in v[8*n-1:0], first byte lowest
    typedef struct packed {
        logic [31:0] v;
        logic [2:0]  n;
        logic        row_end;
    } pix_op_t;

endpackage

// ----- rtl/pfp_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module pfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/pfp_front.sv -----
// ----------------------------------------------------------------------------
// Pixel format packer front end
// Accepts items, serves palette writes and lookups, converts pixels to bytes.
// ----------------------------------------------------------------------------
module pfp_front #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pfp_pkg::in_item_t    s_data,
    input  logic [2:0]           out_format,
    input  logic                 src_indexed,
    input  logic [pfp_pkg::QCW-1:0] q_level,
    output logic                 q_push,
    output pfp_pkg::pix_op_t     q_data
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int QW = pfp_pkg::QCW + 1;

    logic           accept;
    logic           in_range;
    logic [QW-1:0]  committed;
    logic [31:0]    pal_rd;
    logic [31:0]    px;
    logic [31:0]    v;
    logic [2:0]     n;

    logic           f1_valid_reg, f1_valid_next;
    logic [31:0]    f1_color_reg;
    logic           f1_row_end_reg;
    logic           f1_use_pal_reg;
    logic           f1_oob_reg;

    // Credit check: every item in flight has a queue slot reserved
    assign committed = QW'(q_level) + QW'(f1_valid_reg);
    assign s_ready   = committed < QW'(pfp_pkg::QDEPTH);
    assign accept    = s_valid && s_ready;
    assign in_range  = {24'd0, s_data.index} < 32'(PALETTE_DEPTH);

    pfp_ram #(
        .WIDTH (32),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk    (aclk),
        .wr_en   (accept && (s_data.action == pfp_pkg::ACT_PAL_WR) && in_range),
        .wr_addr (s_data.index[AW-1:0]),
        .wr_data (s_data.color),
        .rd_addr (s_data.index[AW-1:0]),
        .rd_data (pal_rd)
    );

    assign f1_valid_next = accept && (s_data.action == pfp_pkg::ACT_PIXEL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
        end else begin
            f1_valid_reg <= f1_valid_next;
        end
        if (accept) begin
            f1_color_reg   <= s_data.color;
            f1_row_end_reg <= s_data.row_end;
            f1_use_pal_reg <= src_indexed;
            f1_oob_reg     <= src_indexed && !in_range;
        end
    end

    // Source pixel: direct, palette, or zero for an index past the palette
    assign px = f1_oob_reg ? 32'd0 : (f1_use_pal_reg ? pal_rd : f1_color_reg);

    always_comb begin
        unique case (out_format)
            pfp_pkg::FMT_RGB555: begin
                v = {17'd0, px[23:19], px[15:11], px[7:3]};
                n = 3'd2;
            end
            pfp_pkg::FMT_RGB565: begin
                v = {16'd0, px[23:19], px[15:10], px[7:3]};
                n = 3'd2;
            end
            pfp_pkg::FMT_RGB24: begin
                v = {8'd0, px[7:0], px[15:8], px[23:16]};
                n = 3'd3;
            end
            pfp_pkg::FMT_BGR24: begin
                v = {8'd0, px[23:0]};
                n = 3'd3;
            end
            pfp_pkg::FMT_ARGB32: begin
                v = px;
                n = 3'd4;
            end
            default: begin
                v = 32'd0;
                n = 3'd0;
            end
        endcase
    end

    assign q_push         = f1_valid_reg;
    assign q_data.v       = v;
    assign q_data.n       = n;
    assign q_data.row_end = f1_row_end_reg;

endmodule

// ----- rtl/pfp_fifo.sv -----
// ----------------------------------------------------------------------------
// Pixel format packer queue
// Short register queue of converted pixels between front and back.
// ----------------------------------------------------------------------------
module pfp_fifo (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  pfp_pkg::pix_op_t        push_data,
    input  logic                    pop,
    output logic                    not_empty,
    output pfp_pkg::pix_op_t        head,
    output logic [pfp_pkg::QCW-1:0] level
);

    pfp_pkg::pix_op_t             entry_reg [pfp_pkg::QDEPTH];
    logic [pfp_pkg::QAW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [pfp_pkg::QAW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [pfp_pkg::QCW-1:0]      level_reg, level_next;

    assign wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    assign level_next  = level_reg + pfp_pkg::QCW'(push) - pfp_pkg::QCW'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign not_empty = level_reg != '0;
    assign head      = entry_reg[rd_ptr_reg];
    assign level     = level_reg;

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |-> level_reg != pfp_pkg::QCW'(pfp_pkg::QDEPTH))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> level_reg != '0)
        else $error("queue underflow");

endmodule

// ----- rtl/pfp_back.sv -----
// ----------------------------------------------------------------------------
// Pixel format packer back end
// Byte accumulator: packs pixel bytes into words, flushes at row end.
// ----------------------------------------------------------------------------
module pfp_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_not_empty,
    input  pfp_pkg::pix_op_t  q_head,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output pfp_pkg::out_item_t m_data
);

    logic [23:0]        pend_reg, pend_next;
    logic [1:0]         pcnt_reg, pcnt_next;
    logic               m_valid_reg, m_valid_next;
    pfp_pkg::out_item_t m_data_reg, m_data_next;
    logic               hold_valid_reg, hold_valid_next;
    pfp_pkg::out_item_t hold_reg, hold_next;

    logic [55:0]        acc;
    logic [55:0]        rem;
    logic [2:0]         cnt;
    logic [2:0]         rem_cnt;
    logic               full;
    logic               flush;
    pfp_pkg::out_item_t res_full;
    pfp_pkg::out_item_t res_tail;
    logic               out_free;

    // Merge the new bytes above the pending ones
    assign acc     = {32'd0, pend_reg} | ({24'd0, q_head.v} << {pcnt_reg, 3'b000});
    assign cnt     = {1'b0, pcnt_reg} + q_head.n;
    assign full    = cnt >= 3'd4;
    assign rem     = full ? (acc >> 32) : acc;
    assign rem_cnt = full ? cnt - 3'd4 : cnt;
    assign flush   = q_head.row_end && (rem_cnt != 3'd0);

    assign res_full.out_word    = acc[31:0];
    assign res_full.bytes_valid = 3'd4;
    assign res_full.last_of_row = q_head.row_end && (rem_cnt == 3'd0);

    assign res_tail.out_word    = rem[31:0];
    assign res_tail.bytes_valid = rem_cnt;
    assign res_tail.last_of_row = 1'b1;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        q_pop           = 1'b0;
        pend_next       = pend_reg;
        pcnt_next       = pcnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (hold_valid_reg) begin
            // second word of the previous item goes first
            if (out_free) begin
                m_valid_next    = 1'b1;
                m_data_next     = hold_reg;
                hold_valid_next = 1'b0;
            end
        end else if (q_not_empty && (out_free || (!full && !flush))) begin
            q_pop     = 1'b1;
            pend_next = q_head.row_end ? 24'd0 : rem[23:0];
            pcnt_next = q_head.row_end ? 2'd0 : rem_cnt[1:0];
            if (full) begin
                m_valid_next = 1'b1;
                m_data_next  = res_full;
                if (flush) begin
                    hold_valid_next = 1'b1;
                    hold_next       = res_tail;
                end
            end else if (flush) begin
                m_valid_next = 1'b1;
                m_data_next  = res_tail;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg       <= 24'd0;
            pcnt_reg       <= 2'd0;
            m_valid_reg    <= 1'b0;
            hold_valid_reg <= 1'b0;
        end else begin
            pend_reg       <= pend_next;
            pcnt_reg       <= pcnt_next;
            m_valid_reg    <= m_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
        m_data_reg <= m_data_next;
        hold_reg   <= hold_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_hold_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> m_valid_reg)
        else $error("held word without a word in the output register");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.bytes_valid != 3'd0) && (m_data_reg.bytes_valid <= 3'd4))
        else $error("byte count out of range");

    a_partial_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg.bytes_valid != 3'd4) |-> m_data_reg.last_of_row)
        else $error("partial word not at row end");

endmodule

// ----- rtl/pixel_format_packer_unit.sv -----
// ----------------------------------------------------------------------------
// Pixel format packer
// Converts direct or palette pixels to RGB555/565, RGB24, BGR24 or ARGB32
// and packs the bytes into little-endian 32-bit words.
// ----------------------------------------------------------------------------
// Throughput: one item per clock while the output takes words; an item that closes a word and also
//   flushes a row tail gives two words and holds the back end until the second word is sent.
// Path: a word reaches m_data through the palette read register, the queue
//   and the output register.
// Reset (aresetn, synchronous): out_format rgb555, direct source, accumulator
//   empty, queue and output empty. Palette contents are not cleared.
// ----------------------------------------------------------------------------
module pixel_format_packer_unit #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic               aclk,
    input  logic               aresetn,

    // configuration write port
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [2:0]         cfg_wdata,

    // input items
    input  logic               s_valid,
    output logic               s_ready,
    input  pfp_pkg::in_item_t  s_data,

    // result items
    output logic               m_valid,
    input  logic               m_ready,
    output pfp_pkg::out_item_t m_data
);

    logic [2:0]              out_format_reg;
    logic                    src_indexed_reg;

    logic                    q_push;
    pfp_pkg::pix_op_t        q_push_data;
    logic                    q_pop;
    logic                    q_not_empty;
    pfp_pkg::pix_op_t        q_head;
    logic [pfp_pkg::QCW-1:0] q_level;

    // Config registers: the user must write them only while idle (not enforced here), so used directly downstream
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_format_reg  <= pfp_pkg::FMT_RGB555;
            src_indexed_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                pfp_pkg::CFG_OUT_FORMAT:  out_format_reg  <= cfg_wdata;
                pfp_pkg::CFG_SRC_INDEXED: src_indexed_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Front: accept, palette access, pixel conversion to bytes
    pfp_front #(
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .out_format  (out_format_reg),
        .src_indexed (src_indexed_reg),
        .q_level     (q_level),
        .q_push      (q_push),
        .q_data      (q_push_data)
    );

    // Queue: decouples the front from output back-pressure
    pfp_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head),
        .level     (q_level)
    );

    // Back: byte accumulator and output register with one spare word
    pfp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
